// ----- rtl/core/dle_pkg.sv -----
// Package for the DLE character-stuffing framer: word types, characters and framing texts.
package dle_pkg;

	// Result buffer: at most 13 words come out of a single input word.
	localparam int unsigned MAX_RES = 13;
	localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);

	// Configuration port
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;
	localparam logic        REG_DIRECTION_SEL = 1'b0;   // paddr[2] for byte address 0

	// Direction codes
	localparam logic DIR_TX = 1'b0;
	localparam logic DIR_RX = 1'b1;

	localparam logic [7:0] CH_D = 8'h64;
	localparam logic [7:0] CH_L = 8'h6C;
	localparam logic [7:0] CH_E = 8'h65;
	localparam logic [7:0] CH_S = 8'h73;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_X = 8'h78;

	localparam logic [7:0] HEAD_TXT [6] = '{CH_D, CH_L, CH_E, CH_S, CH_T, CH_X};
	localparam logic [7:0] TAIL_TXT [6] = '{CH_D, CH_L, CH_E, CH_E, CH_T, CH_X};
	localparam logic [7:0] PAIR_TXT [6] = '{CH_D, CH_L, CH_E, CH_D, CH_L, CH_E};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_frame;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} res_t;

endpackage

// ----- rtl/core/dle_character_stuffing_framer.sv -----
// DLE/STX/ETX character-stuffing framer, transmit and receive, with APB register.
// - Input channel item/item_valid/item_ready carries one byte and an end-of-frame
//   flag per word. Output channel res/res_valid/res_ready carries one byte and a
//   last flag per word. Both are valid/ready; a word moves when both are high.
// - APB register 0 (byte address 0), bit 0: direction. 0 = transmit (add header
//   "dlestx", double every "dle", close with "dleetx"); 1 = receive (drop six header
//   bytes, delay six bytes to strip the trailer, collapse "dledle" to "dle").
//   Write it only while the block is idle; each direction keeps its own state.
// - An accepted word sits in the input register; its results are loaded into the
//   result buffer once that is empty or its last result is taken, and go out on
//   res from there.
// - Throughput: one result word per cycle out of the 13-entry result buffer while
//   res_ready is high. An input word occupies the buffer until its n results
//   (n = 0..13) are out: plain bytes go at one word per cycle, header, escape and
//   trailer bursts hold the input until all their bytes have left.
// - The input register still takes one word while a result waits on res.
// - Receiver stall: res holds; once the buffer and input register are full,
//   item_ready drops and nothing is lost.
// - Reset (arst_n low, asynchronous): buffers empty, direction = transmit, no
//   frame open, receive counters cleared. The receive delay line is not reset.
module dle_character_stuffing_framer
	import dle_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// APB configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// input words
	input  logic              item_valid,
	output logic              item_ready,
	input  item_t             item,
	// result words
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res
);

	// ---------------- configuration ----------------
	logic dir_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_TX;
		end else if (psel && penable && pwrite && paddr[2] == REG_DIRECTION_SEL) begin
			dir_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == REG_DIRECTION_SEL) ? {{(DATA_W-1){1'b0}}, dir_q} : '0;

	// ---------------- input register ----------------
	item_t item_s1;
	logic  vld_s1;
	logic  load;

	assign item_ready = !vld_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			vld_s1 <= 1'b1;
		end else if (load) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// ---------------- framing state ----------------
	logic             tx_in_frame_q, tx_in_frame_d;
	logic [1:0]       tx_pc_q, tx_pc_d;         // 0 none, 1 "d", 2 "dl" held back
	logic [2:0]       rx_hdr_q, rx_hdr_d;       // header bytes dropped, 0..6
	logic [2:0]       rx_fill_q, rx_fill_d;     // valid delay line bytes, 0..6
	logic [1:0]       rx_skip_q, rx_skip_d;     // bytes still to drop after a collapse
	logic [7:0]       rx_dl_q [6];              // delay line, oldest first
	logic [7:0]       rx_dl_d [6];

	// result sequence of the word in the input register
	logic [7:0]       seq [MAX_RES];
	logic [CNT_W-1:0] seq_n;
	logic             seq_last;
	logic [1:0]       pc;
	logic [7:0]       b;
	logic             eof;
	logic             rx_pair;

	always_comb begin
		seq           = '{default: '0};
		seq_n         = '0;
		seq_last      = 1'b0;
		tx_in_frame_d = tx_in_frame_q;
		tx_pc_d       = tx_pc_q;
		rx_hdr_d      = rx_hdr_q;
		rx_fill_d     = rx_fill_q;
		rx_skip_d     = rx_skip_q;
		rx_dl_d       = rx_dl_q;
		b             = item_s1.data_byte;
		eof           = item_s1.end_of_frame;
		pc            = tx_in_frame_q ? tx_pc_q : 2'd0;
		rx_pair       = 1'b1;
		for (int k = 0; k < 6; k++) begin
			if (rx_dl_q[k] != PAIR_TXT[k]) rx_pair = 1'b0;
		end

		if (dir_q == DIR_TX) begin
			// frame opens with the header
			if (!tx_in_frame_q) begin
				for (int k = 0; k < 6; k++) begin
					seq[k] = HEAD_TXT[k];
				end
				seq_n = CNT_W'(6);
			end
			if (pc == 2'd2 && b == CH_E) begin
				// "dle" goes out doubled
				for (int k = 0; k < 6; k++) begin
					seq[seq_n] = PAIR_TXT[k];
					seq_n      = seq_n + 1'b1;
				end
				pc = 2'd0;
			end else if (pc == 2'd1 && b == CH_L) begin
				pc = 2'd2;
			end else begin
				// prefix broken: release held bytes, judge the new byte afresh
				if (pc != 2'd0) begin
					seq[seq_n] = CH_D;
					seq_n      = seq_n + 1'b1;
				end
				if (pc == 2'd2) begin
					seq[seq_n] = CH_L;
					seq_n      = seq_n + 1'b1;
				end
				if (b == CH_D) begin
					pc = 2'd1;
				end else begin
					pc         = 2'd0;
					seq[seq_n] = b;
					seq_n      = seq_n + 1'b1;
				end
			end
			if (eof) begin
				if (pc != 2'd0) begin
					seq[seq_n] = CH_D;
					seq_n      = seq_n + 1'b1;
				end
				if (pc == 2'd2) begin
					seq[seq_n] = CH_L;
					seq_n      = seq_n + 1'b1;
				end
				for (int k = 0; k < 6; k++) begin
					seq[seq_n] = TAIL_TXT[k];
					seq_n      = seq_n + 1'b1;
				end
				seq_last      = 1'b1;
				pc            = 2'd0;
				tx_in_frame_d = 1'b0;
			end else begin
				tx_in_frame_d = 1'b1;
			end
			tx_pc_d = pc;
		end else begin
			seq_last = eof;
			if (rx_hdr_q < 3'd6) begin
				rx_hdr_d = rx_hdr_q + 3'd1;
			end else if (rx_fill_q < 3'd6) begin
				rx_dl_d[rx_fill_q] = b;
				rx_fill_d          = rx_fill_q + 3'd1;
			end else begin
				if (rx_skip_q != 2'd0) begin
					rx_skip_d = rx_skip_q - 2'd1;
				end else if (rx_pair) begin
					seq[0]    = rx_dl_q[3];
					seq_n     = CNT_W'(1);
					rx_skip_d = 2'd3;
				end else begin
					seq[0] = rx_dl_q[0];
					seq_n  = CNT_W'(1);
				end
				for (int k = 0; k < 5; k++) begin
					rx_dl_d[k] = rx_dl_q[k+1];
				end
				rx_dl_d[5] = b;
			end
			// end of frame returns receive state to reset
			if (eof) begin
				rx_hdr_d  = '0;
				rx_fill_d = '0;
				rx_skip_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_in_frame_q <= 1'b0;
			tx_pc_q       <= '0;
			rx_hdr_q      <= '0;
			rx_fill_q     <= '0;
			rx_skip_q     <= '0;
		end else if (load) begin
			tx_in_frame_q <= tx_in_frame_d;
			tx_pc_q       <= tx_pc_d;
			rx_hdr_q      <= rx_hdr_d;
			rx_fill_q     <= rx_fill_d;
			rx_skip_q     <= rx_skip_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rx_dl_q <= rx_dl_d;
		end
	end

	// ---------------- result buffer ----------------
	logic [7:0]       buf_q [MAX_RES];
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] rd_q;
	logic             last_q;
	logic             pop;
	logic             at_end;

	assign res_valid = (rd_q < cnt_q);
	assign pop       = res_valid && res_ready;
	assign at_end    = (rd_q == cnt_q - 1'b1);
	assign load      = vld_s1 && (!res_valid || (pop && at_end));

	assign res.out_byte = buf_q[rd_q];
	assign res.out_last = last_q && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (load) begin
			cnt_q <= seq_n;
			rd_q  <= '0;
		end else if (pop) begin
			rd_q <= rd_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q  <= seq;
			last_q <= seq_last;
		end
	end

	// ---------------- assertions ----------------
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RES))
		else $error("result count beyond buffer depth");

	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_q <= cnt_q)
		else $error("read pointer ran past result count");

	a_skip_full: assert property (@(posedge clk) disable iff (!arst_n)
		rx_skip_q != 2'd0 |-> rx_fill_q == 3'd6)
		else $error("collapse skip pending with delay line not full");

	a_prefix_frame: assert property (@(posedge clk) disable iff (!arst_n)
		tx_pc_q != 2'd0 |-> tx_in_frame_q)
		else $error("prefix held outside an open frame");

endmodule
